// ===== hw/rtl/rwam_pkg.sv =====
// Shared types, codes and mask helpers for the ring window attention mask block.
`default_nettype none

package rwam_pkg;

  // Status codes of a result transaction
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_EMPTY    = 3'd1;
  localparam logic [2:0] STATUS_CONTEXT  = 3'd2;
  localparam logic [2:0] STATUS_HEADROOM = 3'd3;
  localparam logic [2:0] STATUS_ROW      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_RING_ROWS   = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LEN  = 2'd1;
  localparam logic [1:0] CFG_CONTEXT_LEN = 2'd2;

  // Commands
  localparam logic CMD_FULL = 1'b0;
  localparam logic CMD_RING = 1'b1;

  // Register reset values
  localparam logic [12:0] RING_ROWS_RST   = 13'd4096;
  localparam logic [12:0] WINDOW_LEN_RST  = 13'd2048;
  localparam logic [12:0] CONTEXT_LEN_RST = 13'd4096;

  // Signed column position, wide enough for window and offset arithmetic
  typedef logic signed [14:0] pos_t;

  function automatic pos_t pos_max(input pos_t a, input pos_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pos_t pos_min(input pos_t a, input pos_t b);
    return (a < b) ? a : b;
  endfunction

  // Bit j set when column base+j lies below bound
  function automatic logic [63:0] below_mask(input pos_t bound, input logic [11:0] base);
    pos_t        d;
    logic [63:0] m;
    d = bound - $signed({3'b000, base});
    if (d <= 15'sd0) begin
      m = '0;
    end else if (d >= 15'sd64) begin
      m = '1;
    end else begin
      m = ~({64{1'b1}} << d[5:0]);
    end
    return m;
  endfunction

  // Bits of one word whose columns fall in the half-open range [lo, hi)
  function automatic logic [63:0] range_mask(input pos_t lo, input pos_t hi,
                                             input logic [11:0] base);
    return below_mask(hi, base) & ~below_mask(lo, base);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ring_window_attention_mask_top.sv =====
// Top level of the ring window attention mask generator.
`default_nettype none

// Takes one query-row request per start pulse and emits that row's mask as 64-bit
// words, one word per cycle on out_valid, with out_last on the final word. The
// receiver cannot stall: every result shows for exactly one cycle. A request that
// fails a check gives a single error result, registered from the check state. For a
// good row, a 13-step restoring remainder unit, shared between the ring-slot modulo
// and the column padding, runs once for the full causal mask and twice for the ring
// mask before the word emission loop; a row has at most 64 words. busy stays high
// from acceptance until the last word is issued. Configuration writes are taken at
// any time, but are meant only while busy is low.
module ring_window_attention_mask_top #(
  parameter int MAX_CONTEXT = 4096,
  parameter int PAD_COLUMNS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        in_command,
  input  wire logic [11:0] in_chunk_start,
  input  wire logic [12:0] in_chunk_length,
  input  wire logic [11:0] in_query_row,
  // result channel
  output      logic        out_valid,
  output      logic [63:0] out_mask_bits,
  output      logic [5:0]  out_word_index,
  output      logic [2:0]  out_status,
  output      logic        out_last,
  // configuration channel
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam logic [12:0] MaxCtx = 13'(MAX_CONTEXT);
  localparam logic [12:0] Pad    = 13'(PAD_COLUMNS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RMOD,
    ST_PMOD,
    ST_SETUP,
    ST_BOUNDS,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [12:0] ring_rows_r, ring_rows_nxt;
  logic [12:0] window_len_r, window_len_nxt;
  logic [12:0] context_len_r, context_len_nxt;

  // captured request
  logic        cmd_r, cmd_nxt;
  logic [11:0] start_pos_r, start_pos_nxt;
  logic [12:0] len_r, len_nxt;
  logic [11:0] row_r, row_nxt;

  // derived per-item values
  logic [12:0] ring_r, ring_nxt;
  logic [12:0] ctx_r, ctx_nxt;
  logic [12:0] total_r, total_nxt;
  logic [12:0] top_r, top_nxt;
  logic [12:0] q_r, q_nxt;
  rwam_pkg::pos_t qlo_r, qlo_nxt;
  logic [12:0] slot_r, slot_nxt;
  logic [12:0] x_m1_r, x_m1_nxt;
  rwam_pkg::pos_t off_r, off_nxt;
  logic [5:0]  last_idx_r, last_idx_nxt;

  // visible column ranges, half-open
  rwam_pkg::pos_t lo_a_r, lo_a_nxt, hi_a_r, hi_a_nxt;
  rwam_pkg::pos_t lo_b_r, lo_b_nxt, hi_b_r, hi_b_nxt;

  // shared remainder unit
  logic [12:0] div_n_r, div_n_nxt;
  logic [12:0] div_d_r, div_d_nxt;
  logic [12:0] div_rem_r, div_rem_nxt;
  logic [3:0]  div_cnt_r, div_cnt_nxt;
  logic [13:0] div_shift;
  logic        div_ge;
  logic [12:0] div_step;

  // emission counter
  logic [5:0]  word_r, word_nxt;

  // output registers
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_mask_bits_r, out_mask_bits_nxt;
  logic [5:0]  out_word_index_r, out_word_index_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;

  // check stage signals
  logic [12:0] chk_ctx, chk_ring0, chk_ring;
  logic [13:0] chk_total;
  logic [12:0] chk_q;
  logic        chk_headroom;
  logic [2:0]  chk_status;

  // setup stage signals
  logic [13:0] set_padded;
  logic [12:0] set_lim, set_width, set_width_m1;

  // bounds stage signals
  rwam_pkg::pos_t bnd_q1, bnd_t1, bnd_u1, bnd_ring, bnd_r1, bnd_cap;
  logic [12:0]    bnd_cap_u;

  // emission
  logic [11:0] emit_base;
  logic [63:0] emit_mask;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_mask_bits  = out_mask_bits_r;
  assign out_word_index = out_word_index_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  // Restoring remainder step: shift in one dividend bit, subtract when it fits
  always_comb begin
    div_shift = {div_rem_r, div_n_r[12]};
    div_ge    = (div_shift >= {1'b0, div_d_r});
    div_step  = div_ge ? 13'(div_shift - {1'b0, div_d_r}) : div_shift[12:0];
  end

  // Clamp registers and run the error checks on the captured request
  always_comb begin
    chk_ctx   = (context_len_r > MaxCtx) ? MaxCtx : context_len_r;
    chk_ring0 = (ring_rows_r < chk_ctx) ? ring_rows_r : chk_ctx;
    chk_ring  = (chk_ring0 == 13'd0) ? 13'd1 : chk_ring0;
    chk_total = {2'b00, start_pos_r} + {1'b0, len_r};
    chk_q     = {1'b0, start_pos_r} + {1'b0, row_r};
    chk_headroom = (chk_ring < chk_ctx) &&
                   ((window_len_r >= chk_ring) || (len_r > (chk_ring - window_len_r)));
    if (len_r == 13'd0) begin
      chk_status = rwam_pkg::STATUS_EMPTY;
    end else if (chk_total > {1'b0, chk_ctx}) begin
      chk_status = rwam_pkg::STATUS_CONTEXT;
    end else if (chk_headroom) begin
      chk_status = rwam_pkg::STATUS_HEADROOM;
    end else if ({1'b0, row_r} >= len_r) begin
      chk_status = rwam_pkg::STATUS_ROW;
    end else begin
      chk_status = rwam_pkg::STATUS_OK;
    end
  end

  // Padded width, clamped to the ring or context size, and its last column
  always_comb begin
    set_padded   = {1'b0, x_m1_r} - {1'b0, div_rem_r} + {1'b0, Pad};
    set_lim      = (cmd_r == rwam_pkg::CMD_RING) ? ring_r : ctx_r;
    set_width    = (set_padded > {1'b0, set_lim}) ? set_lim : set_padded[12:0];
    set_width_m1 = set_width - 13'd1;
  end

  // Range bound arithmetic
  always_comb begin
    bnd_q1    = $signed({2'b00, q_r}) + 15'sd1;
    bnd_t1    = qlo_r - off_r;
    bnd_u1    = bnd_q1 - off_r;
    bnd_ring  = $signed({2'b00, ring_r});
    bnd_r1    = $signed({2'b00, slot_r}) + 15'sd1;
    bnd_cap_u = (ring_r < total_r) ? ring_r : total_r;
    bnd_cap   = $signed({2'b00, bnd_cap_u});
  end

  // Mask word for the current emission index
  always_comb begin
    emit_base = {word_r, 6'b000000};
    emit_mask = rwam_pkg::range_mask(lo_a_r, hi_a_r, emit_base) |
                rwam_pkg::range_mask(lo_b_r, hi_b_r, emit_base);
  end

  // Sequencer next-state logic
  always_comb begin
    state_nxt          = state_r;
    ring_rows_nxt      = ring_rows_r;
    window_len_nxt     = window_len_r;
    context_len_nxt    = context_len_r;
    cmd_nxt            = cmd_r;
    start_pos_nxt      = start_pos_r;
    len_nxt            = len_r;
    row_nxt            = row_r;
    ring_nxt           = ring_r;
    ctx_nxt            = ctx_r;
    total_nxt          = total_r;
    top_nxt            = top_r;
    q_nxt              = q_r;
    qlo_nxt            = qlo_r;
    slot_nxt           = slot_r;
    x_m1_nxt           = x_m1_r;
    off_nxt            = off_r;
    last_idx_nxt       = last_idx_r;
    lo_a_nxt           = lo_a_r;
    hi_a_nxt           = hi_a_r;
    lo_b_nxt           = lo_b_r;
    hi_b_nxt           = hi_b_r;
    div_n_nxt          = div_n_r;
    div_d_nxt          = div_d_r;
    div_rem_nxt        = div_rem_r;
    div_cnt_nxt        = div_cnt_r;
    word_nxt           = word_r;
    out_valid_nxt      = 1'b0;
    out_mask_bits_nxt  = out_mask_bits_r;
    out_word_index_nxt = out_word_index_r;
    out_status_nxt     = out_status_r;
    out_last_nxt       = out_last_r;

    // take configuration writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwam_pkg::CFG_RING_ROWS:   ring_rows_nxt   = cfg_data;
        rwam_pkg::CFG_WINDOW_LEN:  window_len_nxt  = cfg_data;
        rwam_pkg::CFG_CONTEXT_LEN: context_len_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt       = in_command;
          start_pos_nxt = in_chunk_start;
          len_nxt       = in_chunk_length;
          row_nxt       = in_query_row;
          state_nxt     = ST_CHECK;
        end
      end

      ST_CHECK: begin
        ring_nxt  = chk_ring;
        ctx_nxt   = chk_ctx;
        total_nxt = chk_total[12:0];
        top_nxt   = 13'(chk_total - 14'd1);
        q_nxt     = chk_q;
        qlo_nxt   = $signed({2'b00, chk_q}) - $signed({2'b00, window_len_r}) + 15'sd1;
        if (chk_status != rwam_pkg::STATUS_OK) begin
          // report the error as a single result
          out_valid_nxt      = 1'b1;
          out_mask_bits_nxt  = '0;
          out_word_index_nxt = '0;
          out_status_nxt     = chk_status;
          out_last_nxt       = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          div_n_nxt   = 13'(chk_total - 14'd1);
          x_m1_nxt    = 13'(chk_total - 14'd1);
          div_d_nxt   = (cmd_r == rwam_pkg::CMD_RING) ? chk_ring : Pad;
          div_rem_nxt = '0;
          div_cnt_nxt = 4'd12;
          state_nxt   = (cmd_r == rwam_pkg::CMD_RING) ? ST_RMOD : ST_PMOD;
        end
      end

      ST_RMOD: begin
        div_n_nxt   = {div_n_r[11:0], 1'b0};
        div_rem_nxt = div_step;
        div_cnt_nxt = div_cnt_r - 4'd1;
        if (div_cnt_r == 4'd0) begin
          // newest slot index, then reload for the padding of the ring width
          slot_nxt    = div_step;
          x_m1_nxt    = ((total_r < ring_r) ? total_r : ring_r) - 13'd1;
          div_n_nxt   = ((total_r < ring_r) ? total_r : ring_r) - 13'd1;
          div_d_nxt   = Pad;
          div_rem_nxt = '0;
          div_cnt_nxt = 4'd12;
          state_nxt   = ST_PMOD;
        end
      end

      ST_PMOD: begin
        div_n_nxt   = {div_n_r[11:0], 1'b0};
        div_rem_nxt = div_step;
        div_cnt_nxt = div_cnt_r - 4'd1;
        if (div_cnt_r == 4'd0) begin
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        last_idx_nxt = set_width_m1[11:6];
        off_nxt      = $signed({2'b00, top_r}) - $signed({2'b00, slot_r});
        state_nxt    = ST_BOUNDS;
      end

      ST_BOUNDS: begin
        if (cmd_r == rwam_pkg::CMD_RING) begin
          // slots up to the newest one, then the wrapped slots one lap older
          lo_a_nxt = rwam_pkg::pos_max(15'sd0, bnd_t1);
          hi_a_nxt = rwam_pkg::pos_min(bnd_r1, bnd_u1);
          lo_b_nxt = rwam_pkg::pos_max(bnd_r1, bnd_t1 + bnd_ring);
          hi_b_nxt = rwam_pkg::pos_min(bnd_cap, bnd_u1 + bnd_ring);
        end else begin
          lo_a_nxt = 15'sd0;
          hi_a_nxt = bnd_q1;
          lo_b_nxt = 15'sd0;
          hi_b_nxt = 15'sd0;
        end
        word_nxt  = '0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        out_valid_nxt      = 1'b1;
        out_mask_bits_nxt  = emit_mask;
        out_word_index_nxt = word_r;
        out_status_nxt     = rwam_pkg::STATUS_OK;
        out_last_nxt       = (word_r == last_idx_r);
        word_nxt           = word_r + 6'd1;
        if (word_r == last_idx_r) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, registers and outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      ring_rows_r   <= rwam_pkg::RING_ROWS_RST;
      window_len_r  <= rwam_pkg::WINDOW_LEN_RST;
      context_len_r <= rwam_pkg::CONTEXT_LEN_RST;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      ring_rows_r   <= ring_rows_nxt;
      window_len_r  <= window_len_nxt;
      context_len_r <= context_len_nxt;
    end
    cmd_r            <= cmd_nxt;
    start_pos_r      <= start_pos_nxt;
    len_r            <= len_nxt;
    row_r            <= row_nxt;
    ring_r           <= ring_nxt;
    ctx_r            <= ctx_nxt;
    total_r          <= total_nxt;
    top_r            <= top_nxt;
    q_r              <= q_nxt;
    qlo_r            <= qlo_nxt;
    slot_r           <= slot_nxt;
    x_m1_r           <= x_m1_nxt;
    off_r            <= off_nxt;
    last_idx_r       <= last_idx_nxt;
    lo_a_r           <= lo_a_nxt;
    hi_a_r           <= hi_a_nxt;
    lo_b_r           <= lo_b_nxt;
    hi_b_r           <= hi_b_nxt;
    div_n_r          <= div_n_nxt;
    div_d_r          <= div_d_nxt;
    div_rem_r        <= div_rem_nxt;
    div_cnt_r        <= div_cnt_nxt;
    word_r           <= word_nxt;
    out_mask_bits_r  <= out_mask_bits_nxt;
    out_word_index_r <= out_word_index_nxt;
    out_status_r     <= out_status_nxt;
    out_last_r       <= out_last_nxt;
  end

  // An error result is a lone, empty, final transaction
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != rwam_pkg::STATUS_OK) |->
      out_last && (out_word_index == 6'd0) && (out_mask_bits == 64'd0))
    else $error("error result is not a single empty final word");

  // Words of one row follow each other without gaps, in order
  a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=>
      out_valid && (out_word_index == 6'($past(out_word_index) + 6'd1)))
    else $error("mask words not contiguous");

  // An accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // A new row starts at word zero
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_last) |-> (out_word_index == 6'd0))
    else $error("row does not start at word zero");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ring window attention mask block: directed and random rows.
module tb_top;

  localparam int unsigned CTX_CAP  = 4096;
  localparam int unsigned PAD_COLS = 256;
  localparam int unsigned PHASES   = 8;
  localparam int unsigned PHASE_ITEMS = 55;

  // One 64-column word of a mask row as the block should emit it
  typedef struct packed {
    logic [63:0] bits;
    logic [5:0]  index;
    logic [2:0]  status;
    logic        last;
  } mask_word_t;

  // One directed request; status other than OK is the error typed in by hand
  typedef struct packed {
    logic [2:0]  setting;
    logic        cmd;
    logic [11:0] chunk_start;
    logic [12:0] chunk_length;
    logic [11:0] query_row;
    logic [2:0]  status;
  } mask_case_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [11:0] in_chunk_start;
  logic [12:0] in_chunk_length;
  logic [11:0] in_query_row;
  logic        out_valid;
  logic [63:0] out_mask_bits;
  logic [5:0]  out_word_index;
  logic [2:0]  out_status;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  ring_window_attention_mask_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_chunk_start  (in_chunk_start),
    .in_chunk_length (in_chunk_length),
    .in_query_row    (in_query_row),
    .out_valid       (out_valid),
    .out_mask_bits   (out_mask_bits),
    .out_word_index  (out_word_index),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Mask words still owed by the block, oldest first
  mask_word_t  mask_words_q[$];
  // Shadow copy of the configuration registers
  logic [12:0] ring_rows_m    = rwam_pkg::RING_ROWS_RST;
  logic [12:0] window_len_m   = rwam_pkg::WINDOW_LEN_RST;
  logic [12:0] context_len_m  = rwam_pkg::CONTEXT_LEN_RST;

  int unsigned n_fail        = 0;
  int unsigned n_requests    = 0;
  int unsigned n_words       = 0;
  int unsigned n_error_words = 0;
  int unsigned n_settings    = 0;
  int unsigned burst_left    = 0;

  mask_case_t  dir_cases [25];
  int unsigned dir_ring [5] = '{4096, 1024, 4096, 1, 1};
  int unsigned dir_win  [5] = '{2048, 256, 100, 1, 4096};
  int unsigned dir_ctx  [5] = '{4096, 4096, 300, 1, 4096};
  int unsigned ph_ring  [4] = '{4096, 4096, 1, 4096};
  int unsigned ph_win   [4] = '{2048, 4096, 1, 1};
  int unsigned ph_ctx   [4] = '{4096, 4096, 1, 4096};

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pad_up(input int unsigned x);
    return ((x + PAD_COLS - 1) / PAD_COLS) * PAD_COLS;
  endfunction

  // Work out every word of one requested row and queue it
  function automatic void predict_row_mask(input logic cmd, input logic [11:0] cs,
                                           input logic [12:0] cl, input logic [11:0] qr);
    int unsigned ctx, ring, win, total, q, width, words, col, p, wi, b;
    logic [2:0]  st;
    mask_word_t  w;
    ctx  = (context_len_m > CTX_CAP) ? CTX_CAP : context_len_m;
    ring = (ring_rows_m < ctx) ? ring_rows_m : ctx;
    if (ring == 0) ring = 1;
    win   = window_len_m;
    total = cs + cl;
    q     = cs + qr;
    // Checks in priority order
    if (cl == 0) st = rwam_pkg::STATUS_EMPTY;
    else if (total > ctx) st = rwam_pkg::STATUS_CONTEXT;
    else if (ring < ctx && (win >= ring || cl > ring - win)) st = rwam_pkg::STATUS_HEADROOM;
    else if (qr >= cl) st = rwam_pkg::STATUS_ROW;
    else st = rwam_pkg::STATUS_OK;
    if (st != rwam_pkg::STATUS_OK) begin
      w = '{bits: '0, index: '0, status: st, last: 1'b1};
      mask_words_q.push_back(w);
      return;
    end
    // Padded width, clamped to the cache or ring size
    if (cmd == rwam_pkg::CMD_FULL) begin
      width = pad_up(total);
      if (width > ctx) width = ctx;
    end else begin
      width = pad_up((total < ring) ? total : ring);
      if (width > ring) width = ring;
    end
    words = (width + 63) / 64;
    for (wi = 0; wi < words; wi++) begin
      w.bits = '0;
      for (b = 0; b < 64; b++) begin
        col = wi * 64 + b;
        if (col < width) begin
          if (cmd == rwam_pkg::CMD_FULL) begin
            w.bits[b] = (col <= q);
          end else if (col < ring && col < total) begin
            // Newest position held in this slot
            p = col + ((total - 1 - col) / ring) * ring;
            w.bits[b] = (p <= q) && (p + win > q);
          end
        end
      end
      w.index  = wi[5:0];
      w.status = rwam_pkg::STATUS_OK;
      w.last   = (wi + 1 == words);
      mask_words_q.push_back(w);
    end
  endfunction

  // Hold the request until the block takes it
  task automatic send_request(input logic cmd, input logic [11:0] cs,
                              input logic [12:0] cl, input logic [11:0] qr);
    start           <= 1'b1;
    in_command      <= cmd;
    in_chunk_start  <= cs;
    in_chunk_length <= cl;
    in_query_row    <= qr;
    do @(posedge clk); while (busy);
    n_requests++;
  endtask

  // Drop start and wait until every owed word has come and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (mask_words_q.size() != 0 || busy) @(posedge clk);
  endtask

  // Bursts with random gaps, and now and then a full drain
  task automatic pace_sender();
    int unsigned gap;
    if ($urandom_range(0, 59) == 0) begin
      wait_idle();
    end else if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rwam_pkg::CFG_RING_ROWS:  ring_rows_m   = value;
      rwam_pkg::CFG_WINDOW_LEN: window_len_m  = value;
      default:                  context_len_m = value;
    endcase
  endtask

  // Rewrite all three registers once the block has gone quiet
  task automatic apply_setting(input int unsigned ring, input int unsigned win,
                               input int unsigned ctx);
    wait_idle();
    write_reg(rwam_pkg::CFG_RING_ROWS, ring[12:0]);
    write_reg(rwam_pkg::CFG_WINDOW_LEN, win[12:0]);
    write_reg(rwam_pkg::CFG_CONTEXT_LEN, ctx[12:0]);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Mostly legal rows for the current setting, some near-miss and raw noise
  task automatic next_request(output logic cmd, output logic [11:0] cs,
                              output logic [12:0] cl, output logic [11:0] qr);
    int unsigned ctx, ring, maxlen, len, st, row, kind;
    ctx  = (context_len_m > CTX_CAP) ? CTX_CAP : context_len_m;
    ring = (ring_rows_m < ctx) ? ring_rows_m : ctx;
    if (ring == 0) ring = 1;
    if (ring < ctx) maxlen = (window_len_m < ring) ? ring - window_len_m : 0;
    else maxlen = ctx;
    kind = $urandom_range(0, 9);
    cmd  = 1'($urandom_range(0, 1));
    if (kind < 7 && maxlen > 0) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, maxlen)
                                        : $urandom_range(1, (maxlen < 64) ? maxlen : 64);
      st  = $urandom_range(0, ctx - len);
      case ($urandom_range(0, 2))
        0:       row = len - 1;
        1:       row = $urandom_range(0, len - 1);
        default: row = 0;
      endcase
    end else if (kind == 7) begin
      case ($urandom_range(0, 2))
        0: begin
          len = (maxlen + 1 > 4096) ? 4096 : maxlen + 1;
          st  = 0;
          row = 0;
        end
        1: begin
          len = $urandom_range(1, ctx);
          st  = (ctx - len + 1 > 4095) ? 4095 : ctx - len + 1;
          row = 0;
        end
        default: begin
          len = $urandom_range(1, (maxlen > 0) ? maxlen : ctx);
          st  = 0;
          row = (len > 4095) ? 4095 : len;
        end
      endcase
    end else begin
      st  = $urandom_range(0, 4095);
      len = $urandom_range(0, 4096);
      row = $urandom_range(0, 4095);
    end
    cs = st[11:0];
    cl = len[12:0];
    qr = row[11:0];
  endtask

  // Check each emitted word against the oldest owed one
  always @(posedge clk) begin : word_check
    mask_word_t exp_w;
    if (rst_n && out_valid) begin
      n_words++;
      if (out_status != rwam_pkg::STATUS_OK) n_error_words++;
      if (mask_words_q.size() == 0) begin
        $error("unexpected mask word: index %0d status %0d", out_word_index, out_status);
        n_fail++;
      end else begin
        exp_w = mask_words_q.pop_front();
        if (out_mask_bits !== exp_w.bits) begin
          $error("mask_bits: expected %h, got %h", exp_w.bits, out_mask_bits);
          n_fail++;
        end
        if (out_word_index !== exp_w.index) begin
          $error("word_index: expected %0d, got %0d", exp_w.index, out_word_index);
          n_fail++;
        end
        if (out_status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_status);
          n_fail++;
        end
        if (out_last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, out_last);
          n_fail++;
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int unsigned cur_setting, i, ph, k, guard, r, w, c;
    logic        cmd;
    logic [11:0] cs;
    logic [12:0] cl;
    logic [11:0] qr;

    // setting, command, chunk start, chunk length, query row, typed error
    dir_cases = '{
      // reset registers: smallest rows, empty, past context, largest rows, bad query row
      '{3'd0, rwam_pkg::CMD_FULL, 12'd0,    13'd1,    12'd0,    rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_RING, 12'd0,    13'd1,    12'd0,    rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_FULL, 12'd0,    13'd0,    12'd0,    rwam_pkg::STATUS_EMPTY},
      '{3'd0, rwam_pkg::CMD_RING, 12'd4095, 13'd0,    12'd4095, rwam_pkg::STATUS_EMPTY},
      '{3'd0, rwam_pkg::CMD_FULL, 12'd4095, 13'd2,    12'd0,    rwam_pkg::STATUS_CONTEXT},
      '{3'd0, rwam_pkg::CMD_FULL, 12'd1,    13'd4096, 12'd0,    rwam_pkg::STATUS_CONTEXT},
      '{3'd0, rwam_pkg::CMD_FULL, 12'd0,    13'd4096, 12'd4095, rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_RING, 12'd0,    13'd4096, 12'd4095, rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_RING, 12'd0,    13'd4096, 12'd0,    rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_FULL, 12'd4095, 13'd1,    12'd0,    rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_RING, 12'd4095, 13'd1,    12'd0,    rwam_pkg::STATUS_OK},
      '{3'd0, rwam_pkg::CMD_FULL, 12'd10,   13'd5,    12'd5,    rwam_pkg::STATUS_ROW},
      '{3'd0, rwam_pkg::CMD_RING, 12'd0,    13'd100,  12'd4095, rwam_pkg::STATUS_ROW},
      // small ring: headroom limit and ring wraparound
      '{3'd1, rwam_pkg::CMD_RING, 12'd0,    13'd769,  12'd0,    rwam_pkg::STATUS_HEADROOM},
      '{3'd1, rwam_pkg::CMD_FULL, 12'd0,    13'd769,  12'd0,    rwam_pkg::STATUS_HEADROOM},
      '{3'd1, rwam_pkg::CMD_RING, 12'd1000, 13'd768,  12'd767,  rwam_pkg::STATUS_OK},
      '{3'd1, rwam_pkg::CMD_RING, 12'd3000, 13'd500,  12'd0,    rwam_pkg::STATUS_OK},
      '{3'd1, rwam_pkg::CMD_FULL, 12'd3000, 13'd500,  12'd499,  rwam_pkg::STATUS_OK},
      // ring larger than context, clamped; width not a multiple of the padding
      '{3'd2, rwam_pkg::CMD_RING, 12'd100,  13'd200,  12'd150,  rwam_pkg::STATUS_OK},
      '{3'd2, rwam_pkg::CMD_FULL, 12'd0,    13'd300,  12'd299,  rwam_pkg::STATUS_OK},
      '{3'd2, rwam_pkg::CMD_FULL, 12'd1,    13'd300,  12'd0,    rwam_pkg::STATUS_CONTEXT},
      // one-slot everything
      '{3'd3, rwam_pkg::CMD_FULL, 12'd0,    13'd1,    12'd0,    rwam_pkg::STATUS_OK},
      '{3'd3, rwam_pkg::CMD_RING, 12'd0,    13'd1,    12'd0,    rwam_pkg::STATUS_OK},
      '{3'd3, rwam_pkg::CMD_RING, 12'd0,    13'd2,    12'd0,    rwam_pkg::STATUS_CONTEXT},
      // window covering the whole ring
      '{3'd4, rwam_pkg::CMD_RING, 12'd0,    13'd1,    12'd0,    rwam_pkg::STATUS_HEADROOM}
    };

    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = rwam_pkg::CMD_FULL;
    in_chunk_start  = '0;
    in_chunk_length = '0;
    in_query_row    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = rwam_pkg::CFG_RING_ROWS;
    cfg_data        = '0;
    cur_setting     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (i = 0; i < 25; i++) begin
      if (dir_cases[i].setting != cur_setting) begin
        cur_setting = dir_cases[i].setting;
        apply_setting(dir_ring[cur_setting], dir_win[cur_setting], dir_ctx[cur_setting]);
      end
      send_request(dir_cases[i].cmd, dir_cases[i].chunk_start,
                   dir_cases[i].chunk_length, dir_cases[i].query_row);
      if (dir_cases[i].status != rwam_pkg::STATUS_OK)
        mask_words_q.push_back('{64'd0, 6'd0, dir_cases[i].status, 1'b1});
      else
        predict_row_mask(dir_cases[i].cmd, dir_cases[i].chunk_start,
                         dir_cases[i].chunk_length, dir_cases[i].query_row);
      pace_sender();
    end

    // Random phases: fixed extremes first, then random settings
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        r = ph_ring[ph];
        w = ph_win[ph];
        c = ph_ctx[ph];
      end else begin
        c = $urandom_range(1, 4096);
        r = $urandom_range(0, 1) ? $urandom_range(1, c) : $urandom_range(1, 4096);
        w = (r > 1 && $urandom_range(0, 3) != 0) ? $urandom_range(1, r - 1)
                                                 : $urandom_range(1, 4096);
      end
      apply_setting(r, w, c);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        next_request(cmd, cs, cl, qr);
        send_request(cmd, cs, cl, qr);
        predict_row_mask(cmd, cs, cl, qr);
        pace_sender();
      end
    end

    // Drain, then let the longest row latency pass
    start <= 1'b0;
    for (guard = 0; guard < 20000 && (mask_words_q.size() != 0 || busy); guard++)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mask_words_q.size() != 0) begin
      $error("%0d mask words never arrived", mask_words_q.size());
      n_fail++;
    end

    $display("summary: %0d row requests over %0d register settings", n_requests,
             n_settings + 1);
    $display("summary: %0d mask words checked, %0d of them error results", n_words,
             n_error_words);
    if (n_fail == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
